[rtl/ptc_pkg.sv]
// Package for the pressure/temperature compensation pipeline.
// Holds widths, register and model codes, and the fixed-point constants.
// No dependencies; used by the top level and the port checker.
package ptc_pkg;

  localparam int unsigned RAW_W  = 24;
  localparam int unsigned CAL_W  = 16;
  localparam int unsigned OUT_W  = 17;
  localparam int unsigned APB_AW = 5;
  localparam int unsigned APB_DW = 32;

  // Register stages from input to output register, output register included.
  localparam int unsigned PIPE_DEPTH = 13;

  // Internal datapath widths, sized to the reachable value ranges.
  localparam int unsigned DT_W    = 25;  // D2 - C5*256
  localparam int unsigned PROD1_W = 42;  // dT times a calibration word
  localparam int unsigned DTSQ_W  = 48;  // dT squared
  localparam int unsigned DQ_W    = 18;  // TEMP - 2000
  localparam int unsigned SENS_W  = 36;
  localparam int unsigned OFF_W   = 37;
  localparam int unsigned SQ_W    = 35;  // squares of temperature deltas
  localparam int unsigned TI_W    = 17;
  localparam int unsigned OFFI_W  = 38;
  localparam int unsigned SENSI_W = 37;
  localparam int unsigned TFIN_W  = 20;
  localparam int unsigned SENS2_W = 39;
  localparam int unsigned OFF2_W  = 40;
  localparam int unsigned SPLIT_W = 20;  // low slice of SENS2 for the split multiply
  localparam int unsigned PP_W    = 44;
  localparam int unsigned X_W     = 44;
  localparam int unsigned Y_W     = 32;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned RCP_W   = 25;
  localparam int unsigned Q_W     = 17;

  typedef enum logic [2:0] {
    REG_SENS_T1      = 3'd0,
    REG_OFF_T1       = 3'd1,
    REG_TCS          = 3'd2,
    REG_TCO          = 3'd3,
    REG_T_REF        = 3'd4,
    REG_TEMPSENS     = 3'd5,
    REG_MODEL_SELECT = 3'd6
  } reg_idx_e;

  typedef enum logic {
    MODEL_30BAR = 1'b0,
    MODEL_2BAR  = 1'b1
  } model_e;

  localparam logic signed [DQ_W-1:0]   TEMP_REF   = 18'sd2000;
  localparam logic signed [DQ_W-1:0]   VLOW_LIM   = -18'sd3500;  // TEMP < -1500
  localparam logic signed [DQ_W:0]     VLOW_OFS   = 19'sd3500;   // TEMP + 1500
  localparam logic signed [OUT_W-1:0]  OUT_MAX    = 17'sd65535;
  localparam logic signed [OUT_W-1:0]  OUT_MIN    = 17'sh10000;

  // Clamp limits before the final divide: beyond them the result saturates anyway.
  localparam logic signed [Y_W-1:0] CLAMP_HI_30 = 32'sd655360;
  localparam logic signed [Y_W-1:0] CLAMP_LO_30 = -32'sd655370;
  localparam logic signed [Y_W-1:0] CLAMP_HI_2  = 32'sd6553600;
  localparam logic signed [Y_W-1:0] CLAMP_LO_2  = -32'sd6553700;

  // Reciprocals: ceil(2^28/10) and ceil(2^30/100), exact over the clamped range.
  localparam logic [RCP_W-1:0]  RCP_10    = 25'd26843546;
  localparam logic [RCP_W-1:0]  RCP_100   = 25'd10737419;
  localparam int unsigned       RCP_SH_10  = 28;
  localparam int unsigned       RCP_SH_100 = 30;

endpackage

[rtl/pressure_temp_compensation.sv]
// Top level: APB calibration registers and the 13-stage compensation pipeline.
// Depends on ptc_pkg.
//
//   channel   direction  handshake              payload
//   apb       in/out     psel/penable/pready    paddr, pwdata, prdata
//   in        in         in_valid_i/in_stall_o  raw_pressure_i, raw_temperature_i
//   out       out        out_valid_o/out_stall_i temperature_centi_o, pressure_mbar_o
//
// One reading pair per cycle sustained while out_stall_i is low, through 13 register stages.
// The stage count is set by the chain of multipliers (each product registered).
// Every stage holds a valid bit; a stage with a bubble loads even while the
// output is stalled, so input is stalled only when all 13 stages are full.
// rst_ni clears valid bits and calibration registers (all zero, 30 bar model).
module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [RAW_W-1:0]        raw_pressure_i,
  input  logic [RAW_W-1:0]        raw_temperature_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [OUT_W-1:0] temperature_centi_o,
  output logic signed [OUT_W-1:0] pressure_mbar_o
);

  // Signed division by 2^sh, truncating toward zero.
  function automatic logic signed [63:0] asr_trunc(input logic signed [63:0] v,
                                                   input int unsigned sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

  // ---------------------------------------------------------------- config
  logic [CAL_W-1:0] sens_t1_q, off_t1_q, tcs_q, tco_q, t_ref_q, tempsens_q;
  model_e           model_q;
  logic             wr_en;
  reg_idx_e         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = reg_idx_e'(paddr[APB_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_t1_q  <= '0;
      off_t1_q   <= '0;
      tcs_q      <= '0;
      tco_q      <= '0;
      t_ref_q    <= '0;
      tempsens_q <= '0;
      model_q    <= MODEL_30BAR;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SENS_T1:      sens_t1_q  <= pwdata[CAL_W-1:0];
        REG_OFF_T1:       off_t1_q   <= pwdata[CAL_W-1:0];
        REG_TCS:          tcs_q      <= pwdata[CAL_W-1:0];
        REG_TCO:          tco_q      <= pwdata[CAL_W-1:0];
        REG_T_REF:        t_ref_q    <= pwdata[CAL_W-1:0];
        REG_TEMPSENS:     tempsens_q <= pwdata[CAL_W-1:0];
        REG_MODEL_SELECT: model_q    <= model_e'(pwdata[0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SENS_T1:      prdata = APB_DW'(sens_t1_q);
      REG_OFF_T1:       prdata = APB_DW'(off_t1_q);
      REG_TCS:          prdata = APB_DW'(tcs_q);
      REG_TCO:          prdata = APB_DW'(tco_q);
      REG_T_REF:        prdata = APB_DW'(t_ref_q);
      REG_TEMPSENS:     prdata = APB_DW'(tempsens_q);
      REG_MODEL_SELECT: prdata = {{(APB_DW-1){1'b0}}, model_q};
      default:          prdata = '0;
    endcase
  end

  logic two_bar;
  assign two_bar = (model_q == MODEL_2BAR);

  // ---------------------------------------------------------------- flow control
  logic [PIPE_DEPTH:1]   v_q;
  logic [PIPE_DEPTH:1]   vin;
  logic [PIPE_DEPTH+1:1] rdy;

  assign vin = {v_q[PIPE_DEPTH-1:1], in_valid_i};

  always_comb begin
    rdy[PIPE_DEPTH+1] = !out_stall_i;
    for (int k = PIPE_DEPTH; k >= 1; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o  = !rdy[1];
  assign out_valid_o = v_q[PIPE_DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= PIPE_DEPTH; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // ---------------------------------------------------------------- datapath regs
  logic signed [DT_W-1:0]    s1_dt_q;
  logic [RAW_W-1:0]          s1_d1_q;
  logic signed [PROD1_W-1:0] s2_pt_q, s2_ps_q, s2_po_q;
  logic [DTSQ_W-1:0]         s2_dtsq_q;
  logic [RAW_W-1:0]          s2_d1_q;
  logic signed [DQ_W-1:0]    s3_dq_q;
  logic signed [SENS_W-1:0]  s3_sens_q;
  logic signed [OFF_W-1:0]   s3_off_q;
  logic [DTSQ_W-1:0]         s3_dtsq_q;
  logic [RAW_W-1:0]          s3_d1_q;
  logic signed [DQ_W-1:0]    s4_dq_q;
  logic [SQ_W-1:0]           s4_dd_q, s4_e_q;
  logic                      s4_low_q, s4_vlow_q;
  logic [TI_W-1:0]           s4_ti_q;
  logic signed [SENS_W-1:0]  s4_sens_q;
  logic signed [OFF_W-1:0]   s4_off_q;
  logic [RAW_W-1:0]          s4_d1_q;
  logic [OFFI_W-1:0]         s5_offi_q;
  logic [SENSI_W-1:0]        s5_sensi_q;
  logic signed [TFIN_W-1:0]  s5_tfin_q;
  logic signed [SENS_W-1:0]  s5_sens_q;
  logic signed [OFF_W-1:0]   s5_off_q;
  logic [RAW_W-1:0]          s5_d1_q;
  logic signed [SENS2_W-1:0] s6_sens2_q;
  logic signed [OFF2_W-1:0]  s6_off2_q;
  logic signed [OUT_W-1:0]   s6_t_q;
  logic [RAW_W-1:0]          s6_d1_q;
  logic [PP_W-1:0]           s7_pplo_q;
  logic signed [PP_W-1:0]    s7_pphi_q;
  logic signed [OFF2_W-1:0]  s7_off2_q;
  logic signed [OUT_W-1:0]   s7_t_q;
  logic signed [63:0]        s8_prod_q;
  logic signed [OFF2_W-1:0]  s8_off2_q;
  logic signed [OUT_W-1:0]   s8_t_q;
  logic signed [X_W-1:0]     s9_x_q;
  logic signed [OUT_W-1:0]   s9_t_q;
  logic signed [Y_W-1:0]     s10_y_q;
  logic signed [OUT_W-1:0]   s10_t_q;
  logic [MAG_W-1:0]          s11_mag_q;
  logic                      s11_neg_q;
  logic signed [OUT_W-1:0]   s11_t_q;
  logic [Q_W-1:0]            s12_q_q;
  logic                      s12_neg_q;
  logic signed [OUT_W-1:0]   s12_t_q;
  logic signed [OUT_W-1:0]   out_p_q, out_t_q;

  // ---------------------------------------------------------------- stage logic
  logic signed [DT_W-1:0]        s1_dt_d;
  logic signed [DT_W+DT_W-1:0]   dtsq_full;
  logic signed [CAL_W:0]         c3_s, c4_s, c6_s;
  logic signed [63:0]            t_div, s_div7, s_div8, o_div6, o_div7, sens64, off64;
  logic signed [DQ_W-1:0]        s3_dq_d;
  logic signed [SENS_W-1:0]      s3_sens_d;
  logic signed [OFF_W-1:0]       s3_off_d;
  logic signed [DQ_W+DQ_W-1:0]   dd_full;
  logic signed [DQ_W:0]          ev;
  logic signed [2*DQ_W+1:0]      e_full;
  logic [DTSQ_W+3:0]             dt3, dt11, ti_wide;
  logic [TI_W-1:0]               s4_ti_d;
  logic [OFFI_W+2:0]             dd_w, e_w, offi_w, sensi_w;
  logic signed [TFIN_W-1:0]      s5_tfin_d;
  logic signed [SENS2_W-1:0]     s6_sens2_d;
  logic signed [OFF2_W-1:0]      s6_off2_d;
  logic signed [OUT_W-1:0]       s6_t_d;
  logic signed [63:0]            prod_div, x64, y64;
  logic signed [Y_W-1:0]         y_clamp;
  logic [Y_W-1:0]                y_mag;
  logic [MAG_W+RCP_W-1:0]        rcp_prod;
  logic [Q_W-1:0]                s12_q_d;
  logic signed [Q_W:0]           p_signed;
  logic signed [OUT_W-1:0]       out_p_d;

  assign c3_s = $signed({1'b0, tcs_q});
  assign c4_s = $signed({1'b0, tco_q});
  assign c6_s = $signed({1'b0, tempsens_q});

  assign s1_dt_d   = $signed({1'b0, raw_temperature_i}) - $signed({1'b0, t_ref_q, 8'h00});
  assign dtsq_full = s1_dt_q * s1_dt_q;

  // First order terms
  always_comb begin
    t_div  = asr_trunc(64'(s2_pt_q), 23);
    s_div7 = asr_trunc(64'(s2_ps_q), 7);
    s_div8 = asr_trunc(64'(s2_ps_q), 8);
    o_div6 = asr_trunc(64'(s2_po_q), 6);
    o_div7 = asr_trunc(64'(s2_po_q), 7);
    if (two_bar) begin
      sens64 = $signed(64'(sens_t1_q) << 16) + s_div7;
      off64  = $signed(64'(off_t1_q) << 17) + o_div6;
    end else begin
      sens64 = $signed(64'(sens_t1_q) << 15) + s_div8;
      off64  = $signed(64'(off_t1_q) << 16) + o_div7;
    end
    s3_dq_d   = t_div[DQ_W-1:0];
    s3_sens_d = sens64[SENS_W-1:0];
    s3_off_d  = off64[OFF_W-1:0];
  end

  // Squares and temperature correction
  assign dd_full = s3_dq_q * s3_dq_q;
  assign ev      = (DQ_W+1)'(s3_dq_q) + VLOW_OFS;
  assign e_full  = ev * ev;

  always_comb begin
    dt3  = (DTSQ_W+4)'(s3_dtsq_q) * (DTSQ_W+4)'(3);
    dt11 = (DTSQ_W+4)'(s3_dtsq_q) * (DTSQ_W+4)'(11);
    if (two_bar) begin
      ti_wide = s3_dq_q[DQ_W-1] ? (dt11 >> 35) : '0;
    end else begin
      ti_wide = s3_dq_q[DQ_W-1] ? (dt3 >> 33) : ((DTSQ_W+4)'(s3_dtsq_q) >> 36);
    end
    s4_ti_d = ti_wide[TI_W-1:0];
  end

  // Second order offset and sensitivity terms (all non-negative)
  always_comb begin
    dd_w = (OFFI_W+3)'(s4_dd_q);
    e_w  = (OFFI_W+3)'(s4_e_q);
    offi_w  = '0;
    sensi_w = '0;
    if (s4_low_q) begin
      if (two_bar) begin
        offi_w  = (dd_w * (OFFI_W+3)'(31)) >> 3;
        sensi_w = (dd_w * (OFFI_W+3)'(63)) >> 5;
      end else begin
        offi_w  = (dd_w * (OFFI_W+3)'(3)) >> 1;
        sensi_w = (dd_w * (OFFI_W+3)'(5)) >> 3;
        if (s4_vlow_q) begin
          offi_w  = offi_w + e_w * (OFFI_W+3)'(7);
          sensi_w = sensi_w + (e_w << 2);
        end
      end
    end else if (!two_bar) begin
      offi_w = dd_w >> 4;
    end
    s5_tfin_d = TFIN_W'(s4_dq_q) + TFIN_W'(TEMP_REF) - $signed({3'b0, s4_ti_q});
  end

  always_comb begin
    s6_sens2_d = SENS2_W'(s5_sens_q) - $signed({2'b0, s5_sensi_q});
    s6_off2_d  = OFF2_W'(s5_off_q) - $signed({2'b0, s5_offi_q});
    if (s5_tfin_q > TFIN_W'(OUT_MAX))      s6_t_d = OUT_MAX;
    else if (s5_tfin_q < TFIN_W'(OUT_MIN)) s6_t_d = OUT_MIN;
    else                                   s6_t_d = s5_tfin_q[OUT_W-1:0];
  end

  // Pressure: D1*SENS2/2^21 - OFF2, then the model's scaling
  always_comb begin
    prod_div = asr_trunc(s8_prod_q, 21);
    x64      = prod_div - 64'(s8_off2_q);
    y64      = two_bar ? asr_trunc(64'(s9_x_q), 15) : asr_trunc(64'(s9_x_q), 13);
  end

  always_comb begin
    y_clamp = s10_y_q;
    if (two_bar) begin
      if (s10_y_q > CLAMP_HI_2)      y_clamp = CLAMP_HI_2;
      else if (s10_y_q < CLAMP_LO_2) y_clamp = CLAMP_LO_2;
    end else begin
      if (s10_y_q > CLAMP_HI_30)      y_clamp = CLAMP_HI_30;
      else if (s10_y_q < CLAMP_LO_30) y_clamp = CLAMP_LO_30;
    end
    y_mag = y_clamp[Y_W-1] ? Y_W'(-y_clamp) : Y_W'(y_clamp);
  end

  // Divide magnitude by 10 or 100 with an exact reciprocal multiply
  always_comb begin
    rcp_prod = s11_mag_q * (two_bar ? RCP_100 : RCP_10);
    s12_q_d  = two_bar ? Q_W'(rcp_prod >> RCP_SH_100) : Q_W'(rcp_prod >> RCP_SH_10);
  end

  always_comb begin
    p_signed = s12_neg_q ? -$signed({1'b0, s12_q_q}) : $signed({1'b0, s12_q_q});
    if (p_signed > (Q_W+1)'(OUT_MAX))      out_p_d = OUT_MAX;
    else if (p_signed < (Q_W+1)'(OUT_MIN)) out_p_d = OUT_MIN;
    else                                   out_p_d = p_signed[OUT_W-1:0];
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= raw_pressure_i;
    end
    if (rdy[2]) begin
      s2_pt_q   <= s1_dt_q * c6_s;
      s2_ps_q   <= s1_dt_q * c3_s;
      s2_po_q   <= s1_dt_q * c4_s;
      s2_dtsq_q <= dtsq_full[DTSQ_W-1:0];
      s2_d1_q   <= s1_d1_q;
    end
    if (rdy[3]) begin
      s3_dq_q   <= s3_dq_d;
      s3_sens_q <= s3_sens_d;
      s3_off_q  <= s3_off_d;
      s3_dtsq_q <= s2_dtsq_q;
      s3_d1_q   <= s2_d1_q;
    end
    if (rdy[4]) begin
      s4_dq_q   <= s3_dq_q;
      s4_dd_q   <= dd_full[SQ_W-1:0];
      s4_e_q    <= e_full[SQ_W-1:0];
      s4_low_q  <= s3_dq_q[DQ_W-1];
      s4_vlow_q <= (s3_dq_q < VLOW_LIM);
      s4_ti_q   <= s4_ti_d;
      s4_sens_q <= s3_sens_q;
      s4_off_q  <= s3_off_q;
      s4_d1_q   <= s3_d1_q;
    end
    if (rdy[5]) begin
      s5_offi_q  <= offi_w[OFFI_W-1:0];
      s5_sensi_q <= sensi_w[SENSI_W-1:0];
      s5_tfin_q  <= s5_tfin_d;
      s5_sens_q  <= s4_sens_q;
      s5_off_q   <= s4_off_q;
      s5_d1_q    <= s4_d1_q;
    end
    if (rdy[6]) begin
      s6_sens2_q <= s6_sens2_d;
      s6_off2_q  <= s6_off2_d;
      s6_t_q     <= s6_t_d;
      s6_d1_q    <= s5_d1_q;
    end
    if (rdy[7]) begin
      // 24x39 product split into two partial products
      s7_pplo_q <= s6_d1_q * s6_sens2_q[SPLIT_W-1:0];
      s7_pphi_q <= $signed({1'b0, s6_d1_q}) * $signed(s6_sens2_q[SENS2_W-1:SPLIT_W]);
      s7_off2_q <= s6_off2_q;
      s7_t_q    <= s6_t_q;
    end
    if (rdy[8]) begin
      s8_prod_q <= (64'(s7_pphi_q) <<< SPLIT_W) + $signed(64'(s7_pplo_q));
      s8_off2_q <= s7_off2_q;
      s8_t_q    <= s7_t_q;
    end
    if (rdy[9]) begin
      s9_x_q <= x64[X_W-1:0];
      s9_t_q <= s8_t_q;
    end
    if (rdy[10]) begin
      s10_y_q <= y64[Y_W-1:0];
      s10_t_q <= s9_t_q;
    end
    if (rdy[11]) begin
      s11_mag_q <= y_mag[MAG_W-1:0];
      s11_neg_q <= y_clamp[Y_W-1];
      s11_t_q   <= s10_t_q;
    end
    if (rdy[12]) begin
      s12_q_q   <= s12_q_d;
      s12_neg_q <= s11_neg_q;
      s12_t_q   <= s11_t_q;
    end
    if (rdy[13]) begin
      out_p_q <= out_p_d;
      out_t_q <= s12_t_q;
    end
  end

  assign temperature_centi_o = out_t_q;
  assign pressure_mbar_o     = out_p_q;

endmodule

[rtl/ptc_checker.sv]
// Port-level checker for pressure_temp_compensation, attached by bind.
// Depends on ptc_pkg; tracks transactions in flight from the ports alone.
module ptc_checker
  import ptc_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic signed [OUT_W-1:0] temperature_centi_o,
  input logic signed [OUT_W-1:0] pressure_mbar_o
);

  localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] inflight_q, inflight_d;

  assign in_acc  = in_valid_i & !in_stall_o;
  assign out_acc = out_valid_o & !out_stall_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !out_acc)      inflight_d = inflight_q + CNT_W'(1);
    else if (!in_acc && out_acc) inflight_d = inflight_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // a result only appears for a transaction that was taken in
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (inflight_q != '0))
    else $error("result without a pending transaction");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CNT_W'(PIPE_DEPTH))
    else $error("more transactions in flight than pipeline stages");

  // bubbles collapse: input is only stalled when every stage is full
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (inflight_q < CNT_W'(PIPE_DEPTH)) |-> !in_stall_o)
    else $error("input stalled while the pipeline has room");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(temperature_centi_o) && $stable(pressure_mbar_o)))
    else $error("stalled result changed or dropped");

endmodule

bind pressure_temp_compensation ptc_checker u_ptc_checker (.*);

[verif/pressure_temp_compensation_tb.sv]
// Self-checking testbench for pressure_temp_compensation: programs calibration sets over APB,
// streams reading pairs and checks each one against a 64-bit predictor or a known value.
// Depends on ptc_pkg and the pressure_temp_compensation RTL.
module pressure_temp_compensation_tb;
  import ptc_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] temp;
    logic signed [OUT_W-1:0] pres;
  } reading_t;

  typedef struct packed {
    model_e           model;
    logic [CAL_W-1:0] c1, c2, c3, c4, c5, c6;
  } cal_set_t;

  typedef struct packed {
    logic [2:0]              set;
    logic [RAW_W-1:0]        p_raw;
    logic [RAW_W-1:0]        t_raw;
    logic                    known;
    logic signed [OUT_W-1:0] t_exp;
    logic signed [OUT_W-1:0] p_exp;
  } probe_t;

  // Address one past the last register; writes there must be dropped.
  localparam logic [2:0] REG_NONE = 3'd7;
  localparam logic [RAW_W-1:0] RAW_MAX = 24'hFFFFFF;
  localparam int N_PROBES = 20;

  localparam longint DIV_T     = 64'sd8388608;
  localparam longint DIV_TI_30 = 64'sd8589934592;
  localparam longint DIV_TI_HI = 64'sd137438953472;
  localparam longint DIV_TI_2  = 64'sd34359738368;
  localparam longint DIV_P     = 64'sd2097152;

  localparam cal_set_t CAL_SETS [0:5] = '{
    '{MODEL_30BAR, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{MODEL_30BAR, 16'd34982, 16'd36352, 16'd20328, 16'd22354, 16'd26646, 16'd26146},
    '{MODEL_2BAR, 16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165},
    '{MODEL_30BAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{MODEL_2BAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
    '{MODEL_2BAR, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0}
  };

  // Set 0 is the reset state. Set 1 walks dT = 0, low, very low and high temperatures.
  localparam probe_t PROBES [0:N_PROBES-1] = '{
    '{3'd0, 24'd0, 24'd0, 1'b1, 17'sd2000, 17'sd0},
    '{3'd0, RAW_MAX, RAW_MAX, 1'b1, -17'sd2095, 17'sd0},
    '{3'd0, RAW_MAX, 24'd0, 1'b1, 17'sd2000, 17'sd0},
    '{3'd0, 24'd0, RAW_MAX, 1'b1, -17'sd2095, 17'sd0},
    '{3'd1, 24'd4311550, 24'd8569150, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, 24'd4311550, 24'd6821376, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, 24'd4311550, 24'd6000000, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, 24'd4311550, 24'd5000000, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, 24'd4311550, 24'd0, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, 24'd0, 24'd6821376, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, RAW_MAX, 24'd6821376, 1'b0, 17'sd0, 17'sd0},
    '{3'd1, RAW_MAX, RAW_MAX, 1'b0, 17'sd0, 17'sd0},
    '{3'd2, 24'd6465444, 24'd8077636, 1'b0, 17'sd0, 17'sd0},
    '{3'd2, 24'd6465444, 24'd7000000, 1'b0, 17'sd0, 17'sd0},
    '{3'd2, 24'd0, 24'd0, 1'b0, 17'sd0, 17'sd0},
    '{3'd2, RAW_MAX, RAW_MAX, 1'b0, 17'sd0, 17'sd0},
    '{3'd3, 24'd0, 24'd0, 1'b0, 17'sd0, 17'sd0},
    '{3'd3, RAW_MAX, RAW_MAX, 1'b0, 17'sd0, 17'sd0},
    '{3'd4, RAW_MAX, 24'd0, 1'b0, 17'sd0, 17'sd0},
    '{3'd5, 24'd0, RAW_MAX, 1'b1, 17'sd2000, 17'sd0}
  };

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_AW-1:0]       paddr = '0;
  logic [APB_DW-1:0]       pwdata = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;
  logic                    in_valid_i = 1'b0;
  logic                    in_stall_o;
  logic [RAW_W-1:0]        raw_pressure_i = '0;
  logic [RAW_W-1:0]        raw_temperature_i = '0;
  logic                    out_valid_o;
  logic                    out_stall_i = 1'b0;
  logic signed [OUT_W-1:0] temperature_centi_o;
  logic signed [OUT_W-1:0] pressure_mbar_o;

  cal_set_t cal = CAL_SETS[0];
  reading_t due_readings [$];
  reading_t seen_want;
  int       n_bad = 0;
  int       n_checked = 0;
  int       n_loads = 0;
  int       gap_pct = 20;
  int       stall_pct = 20;
  int       stall_left = 0;

  pressure_temp_compensation u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .raw_pressure_i     (raw_pressure_i),
    .raw_temperature_i  (raw_temperature_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .temperature_centi_o(temperature_centi_o),
    .pressure_mbar_o    (pressure_mbar_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic longint sat17(input longint v);
    if (v > 65535) return 65535;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic reading_t compensate(input logic [RAW_W-1:0] p_raw, t_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, tc, sens, off, ti, offi, sensi, dd, e, p;
    reading_t r;
    d1 = p_raw;
    d2 = t_raw;
    c1 = cal.c1; c2 = cal.c2; c3 = cal.c3;
    c4 = cal.c4; c5 = cal.c5; c6 = cal.c6;
    ti = 0; offi = 0; sensi = 0;
    dt = d2 - c5 * 256;
    tc = 2000 + (dt * c6) / DIV_T;
    if (cal.model == MODEL_2BAR) begin
      sens = c1 * 65536 + (c3 * dt) / 128;
      off = c2 * 131072 + (c4 * dt) / 64;
    end else begin
      sens = c1 * 32768 + (c3 * dt) / 256;
      off = c2 * 65536 + (c4 * dt) / 128;
    end
    dd = (tc - 2000) * (tc - 2000);
    if (cal.model == MODEL_2BAR) begin
      if (tc < 2000) begin
        ti = (11 * dt * dt) / DIV_TI_2;
        offi = (31 * dd) / 8;
        sensi = (63 * dd) / 32;
      end
    end else if (tc < 2000) begin
      ti = (3 * dt * dt) / DIV_TI_30;
      offi = (3 * dd) / 2;
      sensi = (5 * dd) / 8;
      if (tc < -1500) begin
        e = (tc + 1500) * (tc + 1500);
        offi += 7 * e;
        sensi += 4 * e;
      end
    end else begin
      ti = (2 * dt * dt) / DIV_TI_HI;
      offi = dd / 16;
    end
    sens -= sensi;
    off -= offi;
    tc -= ti;
    if (cal.model == MODEL_2BAR) p = (((d1 * sens) / DIV_P - off) / 32768) / 100;
    else p = (((d1 * sens) / DIV_P - off) / 8192) / 10;
    tc = sat17(tc);
    p = sat17(p);
    r.temp = tc[OUT_W-1:0];
    r.pres = p[OUT_W-1:0];
    return r;
  endfunction

  task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_SENS_T1:      cal.c1 = data[CAL_W-1:0];
      REG_OFF_T1:       cal.c2 = data[CAL_W-1:0];
      REG_TCS:          cal.c3 = data[CAL_W-1:0];
      REG_TCO:          cal.c4 = data[CAL_W-1:0];
      REG_T_REF:        cal.c5 = data[CAL_W-1:0];
      REG_TEMPSENS:     cal.c6 = data[CAL_W-1:0];
      REG_MODEL_SELECT: cal.model = model_e'(data[0]);
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Pipeline must be empty before the calibration changes under it.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_readings.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 2) @(negedge clk_i);
  endtask

  // Upper pwdata bits are random junk; the block keeps only the field width.
  task automatic load_cal(input cal_set_t s);
    drain();
    apb_write(REG_SENS_T1, {16'($urandom_range(0, 65535)), s.c1});
    apb_write(REG_OFF_T1, {16'($urandom_range(0, 65535)), s.c2});
    apb_write(REG_TCS, {16'($urandom_range(0, 65535)), s.c3});
    apb_write(REG_TCO, {16'($urandom_range(0, 65535)), s.c4});
    apb_write(REG_T_REF, {16'($urandom_range(0, 65535)), s.c5});
    apb_write(REG_TEMPSENS, {16'($urandom_range(0, 65535)), s.c6});
    apb_write(REG_MODEL_SELECT, {31'($urandom), s.model});
    apb_write(REG_NONE, $urandom);
    n_loads++;
  endtask

  task automatic send_reading(input logic [RAW_W-1:0] p_raw, t_raw, input reading_t want);
    int n;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      n = $urandom_range(1, 13);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    raw_pressure_i <= p_raw;
    raw_temperature_i <= t_raw;
    do @(posedge clk_i); while (in_stall_o);
    due_readings.push_back(want);
  endtask

  function automatic logic [CAL_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return CAL_W'($urandom_range(0, 65535));
    return CAL_W'($urandom_range(15000, 50000));
  endfunction

  // Mostly near the reference temperature so all branches of the correction get hit.
  function automatic logic [RAW_W-1:0] pick_t_raw();
    int v, ofs;
    if ($urandom_range(0, 9) < 3) return RAW_W'($urandom_range(0, 24'hFFFFFF));
    ofs = $urandom_range(0, 6000000);
    v = int'(cal.c5) * 256 + ofs - 3000000;
    if (v < 0) v = 0;
    if (v > 24'hFFFFFF) v = 24'hFFFFFF;
    return v[RAW_W-1:0];
  endfunction

  always @(negedge clk_i) begin
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 13);
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_readings.size() == 0) begin
        $display("%0t: unexpected reading, expected none, got T=%0d P=%0d", $time,
                 temperature_centi_o, pressure_mbar_o);
        n_bad++;
      end else begin
        seen_want = due_readings.pop_front();
        n_checked++;
        if (temperature_centi_o !== seen_want.temp) begin
          $display("%0t: temperature_centi expected %0d got %0d", $time, seen_want.temp,
                   temperature_centi_o);
          n_bad++;
        end
        if (pressure_mbar_o !== seen_want.pres) begin
          $display("%0t: pressure_mbar expected %0d got %0d", $time, seen_want.pres,
                   pressure_mbar_o);
          n_bad++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("pressure_temp_compensation: mismatch");
    $finish;
  end

  initial begin
    logic [2:0] cur_set;
    reading_t   want;
    cal_set_t   s;
    logic [RAW_W-1:0] p_raw, t_raw;
    cur_set = 3'd0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_PROBES; i++) begin
      if (PROBES[i].set != cur_set) begin
        cur_set = PROBES[i].set;
        load_cal(CAL_SETS[cur_set]);
      end
      if (PROBES[i].known) want = '{PROBES[i].t_exp, PROBES[i].p_exp};
      else want = compensate(PROBES[i].p_raw, PROBES[i].t_raw);
      send_reading(PROBES[i].p_raw, PROBES[i].t_raw, want);
    end

    for (int phase = 0; phase < 10; phase++) begin
      s.model = model_e'($urandom_range(0, 1));
      s.c1 = pick_word();
      s.c2 = pick_word();
      s.c3 = pick_word();
      s.c4 = pick_word();
      s.c5 = pick_word();
      s.c6 = pick_word();
      if (phase == 9) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
      end
      load_cal(s);
      for (int k = 0; k < 130; k++) begin
        p_raw = RAW_W'($urandom_range(0, 24'hFFFFFF));
        t_raw = pick_t_raw();
        send_reading(p_raw, t_raw, compensate(p_raw, t_raw));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_readings.size() != 0) @(negedge clk_i);
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);

    $display("checked %0d compensated readings over %0d calibration loads, both models",
             n_checked, n_loads);
    $display("field errors: %0d", n_bad);
    if (n_bad == 0) begin
      $display("pressure_temp_compensation: match");
    end else begin
      $display("pressure_temp_compensation: mismatch");
    end
    $finish;
  end

endmodule
